// ----- sv/p2hf_pkg.sv -----
// p2hf_pkg: shared widths, register map, command/status structs and mask helper
// for the 2bpp horizontal line fill block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package p2hf_pkg;

  localparam int MAX_LINE_PIXELS = 256;
  localparam int MAX_WRITES      = MAX_LINE_PIXELS / 4;

  localparam int COORD_W    = 16;
  localparam int CLIP_W     = 9;
  localparam int COLOR_W    = 2;
  localparam int STRIDE_W   = 8;
  localparam int ADDR_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int BIDX_W     = CLIP_W - 2;
  localparam int PROD_W     = CLIP_W + STRIDE_W;
  localparam int SPAN_W     = COORD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] FILL_UNIT = 8'h55;
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;
  localparam logic [1:0]        SLOT_LAST = 2'd3;

  localparam logic [CLIP_W-1:0]   CLIP_LEFT_RST   = 9'd0;
  localparam logic [CLIP_W-1:0]   CLIP_TOP_RST    = 9'd0;
  localparam logic [CLIP_W-1:0]   CLIP_RIGHT_RST  = 9'd256;
  localparam logic [CLIP_W-1:0]   CLIP_BOTTOM_RST = 9'd256;
  localparam logic [COLOR_W-1:0]  FG_COLOR_RST    = 2'd0;
  localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 8'd64;
  localparam logic [ADDR_W-1:0]   FRAME_BASE_RST  = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_RIGHT  = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_FG_COLOR    = 3'd4,
    REG_LINE_STRIDE = 3'd5,
    REG_FRAME_BASE  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CLIP_W-1:0]   clip_left;
    logic [CLIP_W-1:0]   clip_top;
    logic [CLIP_W-1:0]   clip_right;
    logic [CLIP_W-1:0]   clip_bottom;
    logic [COLOR_W-1:0]  fg_color;
    logic [STRIDE_W-1:0] line_stride;
    logic [ADDR_W-1:0]   frame_base;
  } cfg_regs_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clip;
    logic plan;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic span_ok;
    logic at_end;
  } dp_stat_t;

  // pixels lo..hi of a byte, leftmost pixel in bits 7..6
  function automatic logic [BYTE_W-1:0] pixel_mask(input logic [1:0] lo, input logic [1:0] hi);
    logic [BYTE_W-1:0] m_lo;
    logic [BYTE_W-1:0] m_hi;
    m_lo = BYTE_ONES >> {lo, 1'b0};
    m_hi = BYTE_ONES << {SLOT_LAST - hi, 1'b0};
    return m_lo & m_hi;
  endfunction

endpackage

`default_nettype wire

// ----- sv/p2hf_ifs.sv -----
// p2hf channel interfaces: line command, masked byte write and register write.
// Depends on p2hf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface p2hf_cmd_if import p2hf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_start;
  logic signed [COORD_W-1:0] y_row;
  logic signed [COORD_W-1:0] width;
  modport source (output valid, x_start, y_row, width, input ready);
  modport sink (input valid, x_start, y_row, width, output ready);
endinterface

interface p2hf_wr_if import p2hf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [BYTE_W-1:0] write_data;
  logic [BYTE_W-1:0] bit_mask;
  logic              last_write;
  modport source (output valid, byte_address, write_data, bit_mask, last_write, input ready);
  modport sink (input valid, byte_address, write_data, bit_mask, last_write, output ready);
endinterface

interface p2hf_cfg_if import p2hf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/p2hf_cfg.sv -----
// p2hf_cfg: clip rectangle, colour, stride and base registers.
// Depends on p2hf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p2hf_cfg import p2hf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.clip_left   <= CLIP_LEFT_RST;
      regs_r.clip_top    <= CLIP_TOP_RST;
      regs_r.clip_right  <= CLIP_RIGHT_RST;
      regs_r.clip_bottom <= CLIP_BOTTOM_RST;
      regs_r.fg_color    <= FG_COLOR_RST;
      regs_r.line_stride <= LINE_STRIDE_RST;
      regs_r.frame_base  <= FRAME_BASE_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLIP_LEFT:   regs_r.clip_left   <= cfg_data[CLIP_W-1:0];
        REG_CLIP_TOP:    regs_r.clip_top    <= cfg_data[CLIP_W-1:0];
        REG_CLIP_RIGHT:  regs_r.clip_right  <= cfg_data[CLIP_W-1:0];
        REG_CLIP_BOTTOM: regs_r.clip_bottom <= cfg_data[CLIP_W-1:0];
        REG_FG_COLOR:    regs_r.fg_color    <= cfg_data[COLOR_W-1:0];
        REG_LINE_STRIDE: regs_r.line_stride <= cfg_data[STRIDE_W-1:0];
        REG_FRAME_BASE:  regs_r.frame_base  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/p2hf_dp.sv -----
// p2hf_dp: clipping, row address and per-byte mask/address generation.
// Depends on p2hf_pkg; driven by p2hf_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module p2hf_dp import p2hf_pkg::*; (
  input  logic                      clk,
  input  dp_cmd_t                   cmd,
  input  cfg_regs_t                 regs,
  input  logic signed [COORD_W-1:0] x_start,
  input  logic signed [COORD_W-1:0] y_row,
  input  logic signed [COORD_W-1:0] width,
  output dp_stat_t                  stat,
  output logic [ADDR_W-1:0]         byte_address,
  output logic [BYTE_W-1:0]         write_data,
  output logic [BYTE_W-1:0]         bit_mask
);

  // command capture
  logic signed [COORD_W-1:0] x_r, y_r, w_r;

  // clip stage
  logic signed [SPAN_W-1:0] xs, ws, ys, sum;
  logic signed [SPAN_W-1:0] cl_s, cr_s, ct_s, cb_s;
  logic signed [SPAN_W-1:0] first_nxt, span_end_nxt;
  logic signed [SPAN_W-1:0] first_r, span_end_r;
  logic                     row_ok_r;
  logic [PROD_W-1:0]        prod_nxt, prod_r;

  // plan stage
  logic [CLIP_W-1:0] last_pix;
  logic [BIDX_W-1:0] bfirst, blast, bdiff, bstop;
  logic [ADDR_W-1:0] addr_nxt;

  // emit stage
  logic [ADDR_W-1:0] addr_r;
  logic [BIDX_W-1:0] b_r, bfirst_r, bstop_r, blast_r;
  logic [1:0]        first_lo_r, last_lo_r;
  logic [BYTE_W-1:0] data_r;
  logic [1:0]        lo_slot, hi_slot;

  assign xs   = {{2{x_r[COORD_W-1]}}, x_r};
  assign ws   = {{2{w_r[COORD_W-1]}}, w_r};
  assign ys   = {{2{y_r[COORD_W-1]}}, y_r};
  assign sum  = xs + ws;
  assign cl_s = {{(SPAN_W-CLIP_W){1'b0}}, regs.clip_left};
  assign cr_s = {{(SPAN_W-CLIP_W){1'b0}}, regs.clip_right};
  assign ct_s = {{(SPAN_W-CLIP_W){1'b0}}, regs.clip_top};
  assign cb_s = {{(SPAN_W-CLIP_W){1'b0}}, regs.clip_bottom};

  // span is [first, span_end)
  assign first_nxt    = (xs < cl_s) ? cl_s : xs;
  assign span_end_nxt = (sum > cr_s) ? cr_s : sum;
  assign prod_nxt     = PROD_W'(y_r[CLIP_W-1:0]) * PROD_W'(regs.line_stride);

  // once nonempty, first and span_end sit inside the 9-bit clip range
  assign last_pix = span_end_r[CLIP_W-1:0] - CLIP_W'(1);
  assign bfirst   = first_r[CLIP_W-1:2];
  assign blast    = last_pix[CLIP_W-1:2];
  assign bdiff    = blast - bfirst;
  assign bstop    = (32'(bdiff) >= MAX_WRITES) ? bfirst + BIDX_W'(MAX_WRITES - 1) : blast;
  assign addr_nxt = regs.frame_base + ADDR_W'(prod_r) + ADDR_W'(bfirst);

  assign stat.span_ok = row_ok_r && (span_end_r > first_r);
  assign stat.at_end  = (b_r == bstop_r);

  assign lo_slot = (b_r == bfirst_r) ? first_lo_r : 2'd0;
  assign hi_slot = (b_r == blast_r) ? last_lo_r : SLOT_LAST;

  assign byte_address = addr_r;
  assign write_data   = data_r;
  assign bit_mask     = pixel_mask(lo_slot, hi_slot);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= x_start;
      y_r <= y_row;
      w_r <= width;
    end
    if (cmd.clip) begin
      first_r    <= first_nxt;
      span_end_r <= span_end_nxt;
      row_ok_r   <= (ys >= ct_s) && (ys < cb_s);
      prod_r     <= prod_nxt;
    end
    if (cmd.plan) begin
      addr_r     <= addr_nxt;
      b_r        <= bfirst;
      bfirst_r   <= bfirst;
      bstop_r    <= bstop;
      blast_r    <= blast;
      first_lo_r <= first_r[1:0];
      last_lo_r  <= last_pix[1:0];
      data_r     <= BYTE_W'({{(BYTE_W-COLOR_W){1'b0}}, regs.fg_color} * FILL_UNIT);
    end else if (cmd.step) begin
      addr_r <= addr_r + ADDR_W'(1);
      b_r    <= b_r + BIDX_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- sv/p2hf_ctrl.sv -----
// p2hf_ctrl: sequencer for one line command: capture, clip, plan, emit writes.
// Depends on p2hf_pkg; drives p2hf_dp through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module p2hf_ctrl import p2hf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLIP,
    S_PLAN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign out_last  = stat.at_end;

  assign cmd.load = in_valid && in_ready_r;
  assign cmd.clip = (state_r == S_CLIP);
  assign cmd.plan = (state_r == S_PLAN);
  assign cmd.step = out_valid_r && out_ready;

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          state_nxt    = S_CLIP;
          in_ready_nxt = 1'b0;
        end
      end
      S_CLIP: begin
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        if (stat.span_ok) begin
          state_nxt     = S_EMIT;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready && stat.at_end) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b0;
          in_ready_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
        in_ready_nxt  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready_r)
    else $error("p2hf_ctrl: input open while writes pending");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> out_valid_r)
    else $error("p2hf_ctrl: emit state without valid write");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && stat.at_end) |=> (in_ready_r && !out_valid_r))
    else $error("p2hf_ctrl: last write transfer did not finish the line");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready_r) |=> (!in_ready_r && !out_valid_r))
    else $error("p2hf_ctrl: command transfer not followed by clip step");
`endif

endmodule

`default_nettype wire

// ----- sv/packed_2bpp_hline_fill_top.sv -----
// Sequence: a command transfer is followed by the clip and plan states; the first write of a
// line is valid once plan is done. One command holds the block until its n byte writes (0..64)
// are done, one write per cycle while the sink is ready; the sequencer handles one line at a time.
// Reset: synchronous active-low rst_n clears the sequencer and loads register defaults.
// Depends on p2hf_pkg, p2hf_ifs, p2hf_cfg, p2hf_ctrl and p2hf_dp.
`timescale 1ns / 1ps
`default_nettype none

module packed_2bpp_hline_fill_top import p2hf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  p2hf_cmd_if.sink    in_ch,
  p2hf_wr_if.source   out_ch,
  p2hf_cfg_if.sink    cfg_ch
);

  cfg_regs_t regs;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;
  logic      out_last;
  logic      cfg_ready;

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.last_write = out_last;
  assign cfg_ch.ready      = cfg_ready;

  p2hf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .regs      (regs)
  );

  p2hf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_last  (out_last),
    .stat      (stat),
    .cmd       (cmd)
  );

  p2hf_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .regs         (regs),
    .x_start      (in_ch.x_start),
    .y_row        (in_ch.y_row),
    .width        (in_ch.width),
    .stat         (stat),
    .byte_address (out_ch.byte_address),
    .write_data   (out_ch.write_data),
    .bit_mask     (out_ch.bit_mask)
  );

endmodule

`default_nettype wire
